@@ hw/rtl/crc16fc_pkg.sv @@
// Package for the CRC-16/ARC frame checker: header byte positions,
// the result record and the bytewise CRC update. No dependencies.
package crc16fc_pkg;

    localparam int unsigned POS_W   = 17;
    localparam int unsigned COUNT_W = POS_W + 1;

    localparam logic [POS_W-1:0] POS_TYPE   = 17'd0;
    localparam logic [POS_W-1:0] POS_ID0    = 17'd1;
    localparam logic [POS_W-1:0] POS_ID1    = 17'd2;
    localparam logic [POS_W-1:0] POS_ID2    = 17'd3;
    localparam logic [POS_W-1:0] POS_ID3    = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN0   = 17'd5;
    localparam logic [POS_W-1:0] POS_LEN1   = 17'd6;
    localparam logic [POS_W-1:0] POS_CRC0   = 17'd7;
    localparam logic [POS_W-1:0] POS_CRC1   = 17'd8;
    localparam logic [POS_W-1:0] HDR_BYTES  = 17'd9;
    localparam logic [POS_W-1:0] POS_MAX    = 17'h1FFFF;

    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    localparam int unsigned OUT_TDATA_W = 96;

    typedef struct packed {
        logic        [7:0]  frame_type;
        logic signed [31:0] fragment_id;
        logic        [15:0] payload_length;
        logic        [15:0] crc_received;
        logic        [15:0] crc_computed;
        logic               crc_ok;
        logic               length_mismatch;
    } t_result;

    // Reflected CRC-16, one byte, no final xor.
    function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc_in,
                                                   input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY_REFL;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ hw/rtl/crc16fc_core.sv @@
// Datagram state: header capture, byte count and running CRC.
// Presents the result of the current beat combinationally. Uses crc16fc_pkg.
module crc16fc_core
    import crc16fc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_result     o_result
);

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [7:0]       r_type, n_type;
    logic [31:0]      r_id,   n_id;
    logic [15:0]      r_len,  n_len;
    logic [15:0]      r_crc_rx, n_crc_rx;
    logic [15:0]      r_crc,  n_crc;
    logic [POS_W-1:0] w_pay_idx;
    logic [COUNT_W-1:0] w_count;
    logic [COUNT_W-1:0] w_expect;

    assign w_pay_idx = r_pos - HDR_BYTES;

    always_comb begin
        n_type   = r_type;
        n_id     = r_id;
        n_len    = r_len;
        n_crc_rx = r_crc_rx;
        n_crc    = r_crc;
        case (r_pos)
            POS_TYPE: n_type         = i_byte;
            POS_ID0:  n_id[7:0]      = i_byte;
            POS_ID1:  n_id[15:8]     = i_byte;
            POS_ID2:  n_id[23:16]    = i_byte;
            POS_ID3:  n_id[31:24]    = i_byte;
            POS_LEN0: n_len[7:0]     = i_byte;
            POS_LEN1: n_len[15:8]    = i_byte;
            POS_CRC0: n_crc_rx[7:0]  = i_byte;
            POS_CRC1: n_crc_rx[15:8] = i_byte;
            default: begin
                if (w_pay_idx < {1'b0, r_len}) begin
                    n_crc = crc16_arc_byte(r_crc, i_byte);
                end
            end
        endcase
        n_pos = (r_pos < POS_MAX) ? r_pos + 1'b1 : r_pos;
    end

    assign w_count  = {1'b0, r_pos} + 1'b1;
    assign w_expect = {1'b0, HDR_BYTES} + {2'b00, n_len};

    always_comb begin
        o_result.frame_type      = n_type;
        o_result.fragment_id     = n_id;
        o_result.payload_length  = n_len;
        o_result.crc_received    = n_crc_rx;
        o_result.crc_computed    = n_crc;
        o_result.crc_ok          = (n_crc == n_crc_rx);
        o_result.length_mismatch = (w_count != w_expect);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_type   <= '0;
            r_id     <= '0;
            r_len    <= '0;
            r_crc_rx <= '0;
            r_crc    <= '0;
        end else if (i_en) begin
            if (i_last) begin
                r_pos    <= '0;
                r_type   <= '0;
                r_id     <= '0;
                r_len    <= '0;
                r_crc_rx <= '0;
                r_crc    <= '0;
            end else begin
                r_pos    <= n_pos;
                r_type   <= n_type;
                r_id     <= n_id;
                r_len    <= n_len;
                r_crc_rx <= n_crc_rx;
                r_crc    <= n_crc;
            end
        end
    end

endmodule

@@ hw/rtl/crc16_frame_checker.sv @@
// CRC-16/ARC frame checker top level: input beat register, datagram core,
// result register. Uses crc16fc_pkg and crc16fc_core.
// A result is written to the result register when the beat that carries tlast leaves the
// input register. Throughput: one byte per cycle while no tlast beat is stalled; the
// bytewise CRC update is combinational between the input register and the datagram state.
// A pending result that downstream does not take stalls only beats with tlast.
// Reset (synchronous, active low) clears all datagram state and the valid flags of both stages.
module crc16_frame_checker
    import crc16fc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [7:0]             i_s_tdata,   // [7:0] data_byte
    input  logic                   i_s_tlast,   // datagram_end
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // [7:0] frame_type, [39:8] fragment_id, [55:40] payload_length,
    // [71:56] crc_received, [87:72] crc_computed, [88] crc_ok,
    // [89] length_mismatch, [95:90] zero
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic                   w_out_free;
    logic                   w_adv;
    t_result                w_result;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    crc16fc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_data <= {6'b000000,
                           w_result.length_mismatch,
                           w_result.crc_ok,
                           w_result.crc_computed,
                           w_result.crc_received,
                           w_result.payload_length,
                           w_result.fragment_id,
                           w_result.frame_type};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // a last beat that leaves the input stage always lands in the result register
    a_last_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> r_out_valid)
        else $error("last beat did not produce a result");

    // a last beat never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last && r_out_valid) |-> i_m_tready)
        else $error("result overwritten while stalled");

    // match flag agrees with the two CRC fields it summarizes
    a_crc_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[88] == (o_m_tdata[71:56] == o_m_tdata[87:72])))
        else $error("crc_ok inconsistent with CRC fields");

    // nothing comes out in the cycle right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule
